[rtl/core/color_match_centroid_unit_defines.svh]
// Assertion macros for the color match centroid unit.
// Define NO_ASSERTIONS to compile them away.
`ifndef COLOR_MATCH_CENTROID_UNIT_DEFINES_SVH
`define COLOR_MATCH_CENTROID_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CMC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmc: same-cycle check failed");
`define CMC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmc: next-cycle check failed");
`else
`define CMC_ASSERT_IMP(label, clk, rst, ante, cons)
`define CMC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/cmc_pkg.sv]
// Shared widths, codes and command/status types of the color match centroid unit.
// No dependencies.
`default_nettype none
package cmc_pkg;
   localparam int PixW     = 8;
   localparam int ColW     = 10;
   localparam int RowW     = 10;
   localparam int SumW     = 30;
   localparam int CntW     = 21;
   localparam int DistW    = 18;
   localparam int LineW    = 11;
   localparam int DivSteps = 10;
   localparam int StepW    = $clog2(DivSteps);
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 18;
   localparam int ReqDataW = 24;
   localparam int ReqUserW = 1;
   localparam int RspDataW = 48;
   localparam int RspUserW = 2;

   localparam logic [LineW-1:0] MaxWidth       = 11'd1024;
   localparam logic [LineW-1:0] LineWidthReset = 11'd640;
   localparam logic [DistW-1:0] DistLimitReset = 18'd400;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_REF_BLUE   = 3'd0,
      CSR_REF_GREEN  = 3'd1,
      CSR_REF_RED    = 3'd2,
      CSR_DIST_LIMIT = 3'd3,
      CSR_LINE_WIDTH = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE
   } state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic div_start;
      logic load_centroid;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic count_zero;
      logic div_done;
   } status_type;

   function automatic logic [2*PixW-1:0] sq_diff(input logic [PixW-1:0] a,
                                                input logic [PixW-1:0] b);
      logic [PixW-1:0]   d;
      logic [2*PixW-1:0] dx;
      d  = (a > b) ? (a - b) : (b - a);
      dx = {{PixW{1'b0}}, d};
      return dx * dx;
   endfunction
endpackage
`default_nettype wire

[rtl/core/cmc_ctrl.sv]
// Controller state machine: sequences capture, evaluation and centroid division.
// Depends on cmc_pkg.
`default_nettype none
module cmc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  cmc_pkg::status_type  status,
   output cmc_pkg::cmd_type     cmd
);
   import cmc_pkg::*;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      ready;
   logic      need_div;

   assign need_div = status.frame_end && !status.count_zero;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && ready) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = need_div ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ready             = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_tready);
      cmd.capture       = ready && req_tvalid;
      cmd.eval          = (state_ff == ST_EVAL);
      cmd.div_start     = (state_ff == ST_EVAL) && need_div;
      cmd.load_centroid = (state_ff == ST_DIVIDE) && status.div_done;
      if ((cmd.eval && !need_div) || cmd.load_centroid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = ready;
   assign rsp_tvalid = out_valid_ff;
endmodule
`default_nettype wire

[rtl/core/cmc_div.sv]
// Iterative divider: both coordinate sums by the match count, one quotient bit a cycle.
// Depends on cmc_pkg.
`default_nettype none
module cmc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cmc_pkg::CntW-1:0]   divisor,
   input  logic [cmc_pkg::SumW-1:0]   dvd_col,
   input  logic [cmc_pkg::SumW-1:0]   dvd_row,
   output logic                       done,
   output logic [cmc_pkg::ColW-1:0]   q_col,
   output logic [cmc_pkg::RowW-1:0]   q_row
);
   import cmc_pkg::*;

   logic             busy_ff, busy_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             done_ff, done_in;
   logic [SumW-1:0]  rem_col_ff, rem_col_in;
   logic [SumW-1:0]  rem_row_ff, rem_row_in;
   logic [SumW-1:0]  dsh_ff, dsh_in;
   logic [ColW-1:0]  q_col_ff, q_col_in;
   logic [RowW-1:0]  q_row_ff, q_row_in;
   logic             ge_col, ge_row, last_step;

   assign ge_col    = rem_col_ff >= dsh_ff;
   assign ge_row    = rem_row_ff >= dsh_ff;
   assign last_step = (step_ff == StepW'(DivSteps - 1));

   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      done_in    = 1'b0;
      rem_col_in = rem_col_ff;
      rem_row_in = rem_row_ff;
      dsh_in     = dsh_ff;
      q_col_in   = q_col_ff;
      q_row_in   = q_row_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_col_in = dvd_col;
         rem_row_in = dvd_row;
         dsh_in     = SumW'({divisor, {(DivSteps-1){1'b0}}});
      end else if (busy_ff) begin
         rem_col_in = ge_col ? (rem_col_ff - dsh_ff) : rem_col_ff;
         rem_row_in = ge_row ? (rem_row_ff - dsh_ff) : rem_row_ff;
         q_col_in   = {q_col_ff[ColW-2:0], ge_col};
         q_row_in   = {q_row_ff[RowW-2:0], ge_row};
         dsh_in     = dsh_ff >> 1;
         step_in    = step_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_col_ff <= rem_col_in;
      rem_row_ff <= rem_row_in;
      dsh_ff     <= dsh_in;
      q_col_ff   <= q_col_in;
      q_row_ff   <= q_row_in;
   end

   assign done  = done_ff;
   assign q_col = q_col_ff;
   assign q_row = q_row_ff;
endmodule
`default_nettype wire

[rtl/core/cmc_datapath.sv]
// Datapath: configuration registers, color distance test, position counters,
// running sums and result register. Depends on cmc_pkg and cmc_div.
`default_nettype none
module cmc_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [cmc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [cmc_pkg::CsrDataW-1:0]  csr_data,
   input  logic [cmc_pkg::ReqDataW-1:0]  req_tdata,
   input  logic [cmc_pkg::ReqUserW-1:0]  req_tuser,
   input  logic                          req_tlast,
   output logic [cmc_pkg::RspDataW-1:0]  rsp_tdata,
   output logic [cmc_pkg::RspUserW-1:0]  rsp_tuser,
   output logic                          rsp_tlast,
   input  cmc_pkg::cmd_type              cmd,
   output cmc_pkg::status_type           status
);
   import cmc_pkg::*;

   logic [PixW-1:0]  ref_blue_ff, ref_green_ff, ref_red_ff;
   logic [DistW-1:0] dist_limit_ff;
   logic [LineW-1:0] line_width_ff;

   logic [PixW-1:0]  pix_blue_ff, pix_green_ff, pix_red_ff;
   logic             start_ff, end_ff;

   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [SumW-1:0]  sum_col_ff, sum_col_in;
   logic [SumW-1:0]  sum_row_ff, sum_row_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   logic [PixW-1:0]  out_blue_ff, out_green_ff, out_red_ff;
   logic             match_ff, last_ff, found_ff;
   logic [ColW-1:0]  cen_col_ff;
   logic [RowW-1:0]  cen_row_ff;

   logic [LineW-1:0] w_eff;
   logic [ColW-1:0]  col_start, col_cur;
   logic [RowW-1:0]  row_cur;
   logic [LineW-1:0] col_inc;
   logic [DistW-1:0] dist_sq;
   logic             match, take;
   logic [SumW-1:0]  sum_col_new, sum_row_new;
   logic [CntW-1:0]  cnt_new;
   logic             div_done;
   logic [ColW-1:0]  q_col;
   logic [RowW-1:0]  q_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_blue_ff   <= '0;
         ref_green_ff  <= '0;
         ref_red_ff    <= '0;
         dist_limit_ff <= DistLimitReset;
         line_width_ff <= LineWidthReset;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_REF_BLUE:   ref_blue_ff   <= csr_data[PixW-1:0];
            CSR_REF_GREEN:  ref_green_ff  <= csr_data[PixW-1:0];
            CSR_REF_RED:    ref_red_ff    <= csr_data[PixW-1:0];
            CSR_DIST_LIMIT: dist_limit_ff <= csr_data[DistW-1:0];
            CSR_LINE_WIDTH: line_width_ff <= csr_data[LineW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_blue_ff  <= req_tdata[PixW-1:0];
         pix_green_ff <= req_tdata[2*PixW-1:PixW];
         pix_red_ff   <= req_tdata[3*PixW-1:2*PixW];
         start_ff     <= req_tuser[0];
         end_ff       <= req_tlast;
      end
   end

   always_comb begin
      w_eff = ((line_width_ff == '0) || (line_width_ff > MaxWidth)) ? MaxWidth
                                                                    : line_width_ff;
      col_start = start_ff ? '0 : col_ff;
      col_cur   = ({1'b0, col_start} >= w_eff) ? '0 : col_start;
      row_cur   = start_ff ? '0 : row_ff;

      dist_sq = DistW'(sq_diff(pix_blue_ff, ref_blue_ff))
              + DistW'(sq_diff(pix_green_ff, ref_green_ff))
              + DistW'(sq_diff(pix_red_ff, ref_red_ff));
      match = dist_sq < dist_limit_ff;
      take  = match && !cnt_ff[CntW-1];

      cnt_new     = take ? (cnt_ff + 1'b1) : cnt_ff;
      sum_col_new = take ? (sum_col_ff + SumW'(col_cur)) : sum_col_ff;
      sum_row_new = take ? (sum_row_ff + SumW'(row_cur)) : sum_row_ff;

      col_inc = {1'b0, col_cur} + 1'b1;
      if (col_inc >= w_eff) begin
         col_in = '0;
         row_in = row_cur + 1'b1;
      end else begin
         col_in = col_inc[ColW-1:0];
         row_in = row_cur;
      end

      if (end_ff) begin
         cnt_in     = '0;
         sum_col_in = '0;
         sum_row_in = '0;
      end else begin
         cnt_in     = cnt_new;
         sum_col_in = sum_col_new;
         sum_row_in = sum_row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         sum_col_ff <= '0;
         sum_row_ff <= '0;
         cnt_ff     <= '0;
      end else if (cmd.eval) begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         sum_col_ff <= sum_col_in;
         sum_row_ff <= sum_row_in;
         cnt_ff     <= cnt_in;
      end
   end

   cmc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .divisor (cnt_new),
      .dvd_col (sum_col_new),
      .dvd_row (sum_row_new),
      .done    (div_done),
      .q_col   (q_col),
      .q_row   (q_row)
   );

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         out_blue_ff  <= match ? ref_blue_ff  : pix_blue_ff;
         out_green_ff <= match ? ref_green_ff : pix_green_ff;
         out_red_ff   <= match ? ref_red_ff   : pix_red_ff;
         match_ff     <= match;
         last_ff      <= end_ff;
         found_ff     <= 1'b0;
         cen_col_ff   <= '0;
         cen_row_ff   <= '0;
      end else if (cmd.load_centroid) begin
         found_ff     <= 1'b1;
         cen_col_ff   <= q_col;
         cen_row_ff   <= q_row;
      end
   end

   assign status.frame_end  = end_ff;
   assign status.count_zero = (cnt_new == '0);
   assign status.div_done   = div_done;

   assign rsp_tdata = {{(RspDataW-3*PixW-ColW-RowW){1'b0}},
                       cen_row_ff, cen_col_ff, out_red_ff, out_green_ff, out_blue_ff};
   assign rsp_tuser = {found_ff, match_ff};
   assign rsp_tlast = last_ff;
endmodule
`default_nettype wire

[rtl/core/color_match_centroid_unit.sv]
// Color match centroid unit: top level, controller plus datapath.
// A result word is registered once its pixel has been accepted and evaluated; a frame-end
// pixel with matches first waits for the 10-step shared centroid divider to finish.
// A new pixel is accepted only in idle, once the last result word has been or is being taken.
// Reset is synchronous: configuration registers return to defaults, state, counters and sums clear.
`default_nettype none
`include "color_match_centroid_unit_defines.svh"
module color_match_centroid_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cmc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [cmc_pkg::CsrDataW-1:0]  csr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cmc_pkg::ReqDataW-1:0]  req_tdata,  // pix_blue, pix_green, pix_red
   input  logic [cmc_pkg::ReqUserW-1:0]  req_tuser,  // frame_start
   input  logic                          req_tlast,  // frame_end
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_blue, out_green, out_red, centroid_col, centroid_row, zero pad
   output logic [cmc_pkg::RspDataW-1:0]  rsp_tdata,
   output logic [cmc_pkg::RspUserW-1:0]  rsp_tuser,  // is_match, centroid_found
   output logic                          rsp_tlast   // centroid_ready
);
   import cmc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cmc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .status    (status)
   );

   `CMC_ASSERT_NXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `CMC_ASSERT_IMP(a_div_out_free, clock, reset, status.div_done, !rsp_tvalid)
   `CMC_ASSERT_IMP(a_found_on_last, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast)
endmodule
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for color_match_centroid_unit: pixel stream in, recolored words out.
// A scoreboard class predicts every result word and the frame-end centroid of each frame.
// Depends on cmc_pkg and the color_match_centroid_unit RTL only.
`timescale 1ns / 100ps

module tb_top;
   import cmc_pkg::*;

   localparam int MAX_ROWS    = 1024;
   localparam int COUNT_CAP   = 1 << 20;
   localparam int SETTLE      = 20;
   localparam int LONG_HOLD   = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int PRINT_CAP   = 40;

   typedef struct {
      logic [PixW-1:0] blue;
      logic [PixW-1:0] green;
      logic [PixW-1:0] red;
      logic            frame_start;
      logic            frame_end;
   } pixel_type;

   typedef struct {
      logic [PixW-1:0] out_blue;
      logic [PixW-1:0] out_green;
      logic [PixW-1:0] out_red;
      logic            is_match;
      logic            centroid_ready;
      logic            centroid_found;
      logic [ColW-1:0] centroid_col;
      logic [RowW-1:0] centroid_row;
   } pixel_result_type;

   class centroid_scoreboard;
      logic [PixW-1:0]  ref_blue;
      logic [PixW-1:0]  ref_green;
      logic [PixW-1:0]  ref_red;
      logic [DistW-1:0] dist_limit;
      logic [LineW-1:0] line_width;
      int unsigned      col_pos;
      int unsigned      row_pos;
      int unsigned      col_sum;
      int unsigned      row_sum;
      int unsigned      match_total;
      pixel_result_type pending_results[$];
      int               mismatch_count;
      int               pixels_noted;
      int               words_checked;
      int               frames_ended;
      int               centroids_found;

      function new();
         ref_blue        = '0;
         ref_green       = '0;
         ref_red         = '0;
         dist_limit      = DistLimitReset;
         line_width      = LineWidthReset;
         col_pos         = 0;
         row_pos         = 0;
         col_sum         = 0;
         row_sum         = 0;
         match_total     = 0;
         mismatch_count  = 0;
         pixels_noted    = 0;
         words_checked   = 0;
         frames_ended    = 0;
         centroids_found = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CsrDataW-1:0] value);
         case (idx)
            CSR_REF_BLUE:   ref_blue   = value[PixW-1:0];
            CSR_REF_GREEN:  ref_green  = value[PixW-1:0];
            CSR_REF_RED:    ref_red    = value[PixW-1:0];
            CSR_DIST_LIMIT: dist_limit = value[DistW-1:0];
            CSR_LINE_WIDTH: line_width = value[LineW-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      function logic [DistW-1:0] color_dist(pixel_type px);
         int db, dg, dr;
         db = int'(px.blue) - int'(ref_blue);
         dg = int'(px.green) - int'(ref_green);
         dr = int'(px.red) - int'(ref_red);
         return DistW'(db * db + dg * dg + dr * dr);
      endfunction

      function void predict_pixel(pixel_type px);
         pixel_result_type want;
         int unsigned      width_eff;
         width_eff = (line_width == 0 || line_width > MaxWidth) ? MaxWidth : line_width;
         pixels_noted++;
         if (px.frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         if (col_pos >= width_eff) col_pos = 0;
         if (row_pos >= MAX_ROWS) row_pos = 0;

         want.is_match       = color_dist(px) < dist_limit;
         want.centroid_ready = px.frame_end;
         want.centroid_found = 1'b0;
         want.centroid_col   = '0;
         want.centroid_row   = '0;
         if (want.is_match) begin
            want.out_blue  = ref_blue;
            want.out_green = ref_green;
            want.out_red   = ref_red;
            if (match_total < COUNT_CAP) begin
               match_total++;
               col_sum += col_pos & 1023;
               row_sum += row_pos & 1023;
            end
         end else begin
            want.out_blue  = px.blue;
            want.out_green = px.green;
            want.out_red   = px.red;
         end

         if (px.frame_end) begin
            frames_ended++;
            if (match_total != 0) begin
               centroids_found++;
               want.centroid_found = 1'b1;
               want.centroid_col   = ColW'(col_sum / match_total);
               want.centroid_row   = RowW'(row_sum / match_total);
            end
            col_sum     = 0;
            row_sum     = 0;
            match_total = 0;
         end

         col_pos++;
         if (col_pos >= width_eff) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= MAX_ROWS) row_pos = 0;
         end
         pending_results.push_back(want);
      endfunction

      task report_mismatch(string msg);
         mismatch_count++;
         if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch at word %0d: %s", $realtime, words_checked, msg);
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
      endtask

      task check_word(pixel_result_type got);
         pixel_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result word with no pixel outstanding");
            return;
         end
         want = pending_results.pop_front();
         compare_field("out_blue", got.out_blue, want.out_blue);
         compare_field("out_green", got.out_green, want.out_green);
         compare_field("out_red", got.out_red, want.out_red);
         compare_field("is_match", got.is_match, want.is_match);
         compare_field("centroid_ready", got.centroid_ready, want.centroid_ready);
         compare_field("centroid_found", got.centroid_found, want.centroid_found);
         compare_field("centroid_col", got.centroid_col, want.centroid_col);
         compare_field("centroid_row", got.centroid_row, want.centroid_row);
         words_checked++;
      endtask
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CsrIdxW-1:0]  csr_index  = '0;
   logic [CsrDataW-1:0] csr_data   = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic [ReqUserW-1:0] req_tuser  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [RspUserW-1:0] rsp_tuser;
   logic                rsp_tlast;

   centroid_scoreboard sb;
   bit source_steady     = 1'b1;
   bit sink_steady       = 1'b1;
   bit sink_hold_request = 1'b0;
   int quiet_cycles      = 0;

   color_match_centroid_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pix_blue, pix_green, pix_red
      .req_tuser  (req_tuser),   // frame_start
      .req_tlast  (req_tlast),   // frame_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_blue, out_green, out_red, centroid_col, centroid_row
      .rsp_tuser  (rsp_tuser),   // is_match, centroid_found
      .rsp_tlast  (rsp_tlast)    // centroid_ready
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      pixel_type        px;
      pixel_result_type got;
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.set_register(csr_index_type'(csr_index), csr_data);
         if (req_tvalid && req_tready) begin
            px.blue        = req_tdata[7:0];
            px.green       = req_tdata[15:8];
            px.red         = req_tdata[23:16];
            px.frame_start = req_tuser[0];
            px.frame_end   = req_tlast;
            sb.predict_pixel(px);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.out_blue       = rsp_tdata[7:0];
            got.out_green      = rsp_tdata[15:8];
            got.out_red        = rsp_tdata[23:16];
            got.centroid_col   = rsp_tdata[33:24];
            got.centroid_row   = rsp_tdata[43:34];
            got.is_match       = rsp_tuser[0];
            got.centroid_found = rsp_tuser[1];
            got.centroid_ready = rsp_tlast;
            sb.check_word(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result sink: random stalls, steady stretches, and one long hold on request
   initial begin : rsp_sink
      int r;
      forever begin
         r = $urandom_range(0, 99);
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (sink_steady || r < 70) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clock);
            else repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (source_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PixW-1:0] near_value(logic [PixW-1:0] center, bit exact);
      int v;
      if (exact) return center;
      v = int'(center) + int'($urandom_range(0, 32)) - 16;
      if (v < 0) return '0;
      if (v > 255) return 8'd255;
      return PixW'(v);
   endfunction

   function automatic pixel_type make_pixel(bit sof, bit eof, int near_pct);
      pixel_type px;
      bit        exact;
      if ($urandom_range(0, 99) < near_pct) begin
         exact    = ($urandom_range(0, 3) == 0);
         px.blue  = near_value(sb.ref_blue, exact);
         px.green = near_value(sb.ref_green, exact);
         px.red   = near_value(sb.ref_red, exact);
      end else begin
         px.blue  = PixW'($urandom);
         px.green = PixW'($urandom);
         px.red   = PixW'($urandom);
      end
      px.frame_start = sof;
      px.frame_end   = eof;
      return px;
   endfunction

   function automatic pixel_type fixed_pixel(int b, int g, int r, bit sof, bit eof);
      pixel_type px;
      px.blue        = PixW'(b);
      px.green       = PixW'(g);
      px.red         = PixW'(r);
      px.frame_start = sof;
      px.frame_end   = eof;
      return px;
   endfunction

   task automatic send_pixel(pixel_type px);
      int gap;
      gap = pick_gap();
      req_tvalid <= 1'b1;
      req_tdata  <= {px.red, px.green, px.blue};
      req_tuser  <= px.frame_start;
      req_tlast  <= px.frame_end;
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame(int len, bit sof, bit eof, int near_pct);
      for (int i = 0; i < len; i++)
         send_pixel(make_pixel(sof && i == 0, eof && i == len - 1, near_pct));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CsrDataW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(int b, int g, int r, int limit, int width);
      wait_idle();
      write_register(CSR_REF_BLUE, CsrDataW'(b));
      write_register(CSR_REF_GREEN, CsrDataW'(g));
      write_register(CSR_REF_RED, CsrDataW'(r));
      write_register(CSR_DIST_LIMIT, CsrDataW'(limit));
      write_register(CSR_LINE_WIDTH, CsrDataW'(width));
   endtask

   // mostly whole frames with random content, some with a missing mark, some loose pixels
   task automatic random_traffic(int items, int max_len, int near_pct);
      int sent, len, r;
      bit sof;
      sent = 0;
      while (sent < items) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) source_steady = !source_steady;
         if ($urandom_range(0, 19) == 0) sink_steady = !sink_steady;
         if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 4 * max_len);
         else len = $urandom_range(1, max_len);
         if (r < 80) begin
            send_frame(len, 1'b1, 1'b1, near_pct);
         end else if (r < 92) begin
            sof = $urandom_range(0, 1);
            send_frame(len, sof, !sof, near_pct);
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               send_pixel(make_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                                     near_pct));
         end
         sent += len;
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: reference black, limit 400, 640-pixel lines
      send_pixel(fixed_pixel(0, 0, 0, 1, 1));
      send_pixel(fixed_pixel(255, 255, 255, 1, 1));
      send_pixel(fixed_pixel(0, 0, 0, 1, 0));
      send_pixel(fixed_pixel(20, 0, 0, 0, 0));
      send_pixel(fixed_pixel(19, 6, 1, 0, 0));
      send_pixel(fixed_pixel(0, 0, 19, 0, 0));
      send_pixel(fixed_pixel(11, 11, 11, 0, 0));
      send_pixel(fixed_pixel(12, 12, 12, 0, 0));
      send_pixel(fixed_pixel(255, 0, 0, 0, 0));
      send_pixel(fixed_pixel(0, 255, 0, 0, 0));
      send_pixel(fixed_pixel(0, 0, 255, 0, 0));
      send_pixel(fixed_pixel(0, 19, 6, 0, 1));
      send_pixel(fixed_pixel(3, 0, 0, 0, 1));
      send_pixel(fixed_pixel(200, 100, 50, 0, 1));
      send_pixel(fixed_pixel(1, 1, 1, 1, 0));
      send_pixel(fixed_pixel(255, 255, 255, 0, 0));
      send_pixel(fixed_pixel(0, 0, 0, 1, 0));
      send_pixel(fixed_pixel(5, 5, 5, 0, 1));

      source_steady = 1'b0;
      sink_steady   = 1'b0;
      apply_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     400, $urandom_range(1, 24));
      random_traffic(80, 12, 50);

      // nothing can match
      apply_settings(255, 255, 255, 0, 1);
      random_traffic(20, 8, 50);

      // everything matches; an out-of-range width acts as the maximum and the column wraps
      apply_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     262143, 2047);
      send_frame(1026, 1'b1, 1'b1, 50);
      send_frame(5, 1'b1, 1'b1, 50);

      // a zero width also behaves as the maximum
      apply_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(100, 3000), 0);
      random_traffic(20, 10, 50);

      // one-pixel lines: every pixel starts a new row
      apply_settings(0, 0, 0, 195075, 1);
      send_pixel(fixed_pixel(255, 255, 255, 1, 0));
      send_pixel(fixed_pixel(254, 255, 255, 0, 1));
      send_frame(12, 1'b1, 1'b1, 40);

      // hold the sink off while the source keeps offering pixels
      apply_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(1, 5000), $urandom_range(1, 40));
      source_steady     = 1'b1;
      sink_hold_request = 1'b1;
      send_frame(60, 1'b1, 1'b1, 60);
      wait_idle();
      source_steady = 1'b0;
      random_traffic(30, 16, 50);

      // only an exact color matches
      apply_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     1, $urandom_range(1, 8));
      random_traffic(20, 10, 60);

      wait_idle();
      $display("Checked %0d result words for %0d pixels; %0d frame ends, %0d with a centroid.",
               sb.words_checked, sb.pixels_noted, sb.frames_ended, sb.centroids_found);
      $display("Settings covered: reset values, no-match and all-match limits, out-of-range %s",
               "widths with a full-width column wrap, one-pixel lines and sink back-pressure.");
      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
